/* rtl/ovwp_pkg.sv */
`timescale 1ns / 1ps

package ovwp_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 40;

   localparam logic [CSR_INDEX_W-1:0] CSR_WAVEFORM = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEREO   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TUNING   = 2'd2;

   localparam logic [39:0] TUNING_RESET = 40'd5864062015;

   typedef enum logic [1:0] {
      WAVE_SINE,
      WAVE_SQUARE,
      WAVE_SAW,
      WAVE_TRIANGLE
   } wave_type;

   typedef enum logic [2:0] {
      MUL_INC_LO,
      MUL_INC_HI,
      MUL_IDX,
      MUL_GAIN,
      MUL_LEFT_HI,
      MUL_LEFT_LO,
      MUL_RIGHT_HI,
      MUL_RIGHT_LO
   } mul_sel_type;

   typedef struct packed {
      logic [23:0]        frequency;
      logic signed [15:0] volume;
      logic signed [15:0] pan;
   } req_type;

   typedef struct packed {
      logic signed [23:0] left_sample;
      logic signed [23:0] right_sample;
   } rsp_type;

   typedef struct packed {
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        part_en;
      logic        inc_en;
      logic        rom_en;
      logic        wave_en;
      logic        gain_en;
      logic        mono_en;
      logic        left_en;
      logic        right_en;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic stereo;
      logic out_free;
   } sts_type;

   function automatic logic signed [23:0] sat24(input logic signed [53:0] x);
      logic signed [23:0] r;
      if (x > 54'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (x < -54'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = x[23:0];
      end
      return r;
   endfunction

endpackage

/* rtl/ovwp_ctrl.sv */
`timescale 1ns / 1ps

module ovwp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  ovwp_pkg::sts_type sts,
   output logic             busy,
   output ovwp_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INC_LO,
      ST_INC_HI,
      ST_IDX,
      ST_ROM,
      ST_WAVE,
      ST_GAIN,
      ST_GAIN_SAVE,
      ST_LEFT_HI,
      ST_LEFT_LO,
      ST_LEFT_SUM,
      ST_RIGHT_HI,
      ST_RIGHT_LO,
      ST_RIGHT_SUM,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   ovwp_pkg::cmd_type cmd_ff, cmd_in;

   function automatic ovwp_pkg::cmd_type decode(input state_type s);
      ovwp_pkg::cmd_type c;
      c = '0;
      case (s)
         ST_INC_LO: begin
            c.mul_en  = 1'b1;
            c.mul_sel = ovwp_pkg::MUL_INC_LO;
         end
         ST_INC_HI: begin
            c.mul_en  = 1'b1;
            c.mul_sel = ovwp_pkg::MUL_INC_HI;
            c.part_en = 1'b1;
         end
         ST_IDX: begin
            c.mul_en  = 1'b1;
            c.mul_sel = ovwp_pkg::MUL_IDX;
            c.inc_en  = 1'b1;
         end
         ST_ROM:  c.rom_en  = 1'b1;
         ST_WAVE: c.wave_en = 1'b1;
         ST_GAIN: begin
            c.mul_en  = 1'b1;
            c.mul_sel = ovwp_pkg::MUL_GAIN;
         end
         ST_GAIN_SAVE: begin
            c.gain_en = 1'b1;
            c.mono_en = 1'b1;
         end
         ST_LEFT_HI: begin
            c.mul_en  = 1'b1;
            c.mul_sel = ovwp_pkg::MUL_LEFT_HI;
         end
         ST_LEFT_LO: begin
            c.mul_en  = 1'b1;
            c.mul_sel = ovwp_pkg::MUL_LEFT_LO;
            c.part_en = 1'b1;
         end
         ST_LEFT_SUM: c.left_en = 1'b1;
         ST_RIGHT_HI: begin
            c.mul_en  = 1'b1;
            c.mul_sel = ovwp_pkg::MUL_RIGHT_HI;
         end
         ST_RIGHT_LO: begin
            c.mul_en  = 1'b1;
            c.mul_sel = ovwp_pkg::MUL_RIGHT_LO;
            c.part_en = 1'b1;
         end
         ST_RIGHT_SUM: c.right_en = 1'b1;
         ST_DONE:      c.finish   = 1'b1;
         default:      c = '0;
      endcase
      return c;
   endfunction

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (accept) state_in = ST_INC_LO;
         ST_INC_LO:    state_in = ST_INC_HI;
         ST_INC_HI:    state_in = ST_IDX;
         ST_IDX:       state_in = ST_ROM;
         ST_ROM:       state_in = ST_WAVE;
         ST_WAVE:      state_in = ST_GAIN;
         ST_GAIN:      state_in = ST_GAIN_SAVE;
         ST_GAIN_SAVE: state_in = sts.stereo ? ST_LEFT_HI : ST_DONE;
         ST_LEFT_HI:   state_in = ST_LEFT_LO;
         ST_LEFT_LO:   state_in = ST_LEFT_SUM;
         ST_LEFT_SUM:  state_in = ST_RIGHT_HI;
         ST_RIGHT_HI:  state_in = ST_RIGHT_LO;
         ST_RIGHT_LO:  state_in = ST_RIGHT_SUM;
         ST_RIGHT_SUM: state_in = ST_DONE;
         ST_DONE:      if (sts.out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
      cmd_in = decode(state_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cmd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign cmd  = cmd_ff;

endmodule

/* rtl/ovwp_datapath.sv */
`timescale 1ns / 1ps

module ovwp_datapath #(
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [ovwp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ovwp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                load,
   input  ovwp_pkg::req_type                   req_data,
   input  ovwp_pkg::cmd_type                   cmd,
   output ovwp_pkg::sts_type                   sts,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ovwp_pkg::rsp_type                   rsp_data
);

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

   typedef logic [15:0] rom_type [SINE_TABLE_DEPTH];

   // quarter-wave entry i: sine at (i + 0.5) / depth of a quarter turn, Q30 Taylor to x^13
   function automatic logic [15:0] sine_entry(input int unsigned i);
      logic [63:0]        x;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] v;
      x    = (64'd1686629713 * (64'(i) * 64'd2 + 64'd1)) / (2 * SINE_TABLE_DEPTH);
      term = x;
      sum  = $signed(x);
      for (int k = 1; k <= 6; k++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         case (k)
            1:       term = term / 6;
            2:       term = term / 20;
            3:       term = term / 42;
            4:       term = term / 72;
            5:       term = term / 110;
            default: term = term / 156;
         endcase
         if ((k % 2) == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
      if (v > 64'sd32767) begin
         v = 64'sd32767;
      end
      return v[15:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type r;
      for (int unsigned i = 0; i < SINE_TABLE_DEPTH; i++) begin
         r[i] = sine_entry(i);
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // configuration
   ovwp_pkg::wave_type wave_sel_ff;
   logic               stereo_ff;
   logic [39:0]        tuning_ff;

   // item state
   logic [23:0]        freq_ff;
   logic signed [15:0] vol_ff;
   logic signed [15:0] pan_ff;
   logic [31:0]        phase_ff;
   logic               prev_zero_ff;

   // working registers
   logic signed [53:0] prod_ff, prod_in;
   logic signed [53:0] part_ff;
   logic [31:0]        inc_ff, inc_in;
   logic [15:0]        rom_ff;
   logic signed [16:0] wave_ff, wave_in;
   logic signed [32:0] gain_ff;
   logic signed [23:0] left_ff, right_ff;
   logic signed [23:0] left_in, right_in, mono_in;

   ovwp_pkg::rsp_type  rsp_data_ff;
   logic               rsp_valid_ff;
   logic               out_free;

   logic signed [31:0] mul_a;
   logic signed [21:0] mul_b;
   logic signed [17:0] fac_left, fac_right;
   logic [55:0]        inc_sum;
   logic [IDX_W-1:0]   idx_raw, idx_m;
   logic [16:0]        tri_u;
   logic signed [53:0] pan_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_sel_ff <= ovwp_pkg::WAVE_SINE;
         stereo_ff   <= 1'b1;
         tuning_ff   <= ovwp_pkg::TUNING_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            ovwp_pkg::CSR_WAVEFORM: wave_sel_ff <= ovwp_pkg::wave_type'(csr_wdata[1:0]);
            ovwp_pkg::CSR_STEREO:   stereo_ff   <= csr_wdata[0];
            ovwp_pkg::CSR_TUNING:   tuning_ff   <= csr_wdata[39:0];
            default: ;
         endcase
      end
   end

   assign fac_left  = 18'sd32768 - 18'(pan_ff);
   assign fac_right = 18'sd32768 + 18'(pan_ff);

   // shared multiplier operand selection
   always_comb begin
      case (cmd.mul_sel)
         ovwp_pkg::MUL_INC_LO: begin
            mul_a = $signed({8'b0, freq_ff});
            mul_b = $signed({2'b0, tuning_ff[19:0]});
         end
         ovwp_pkg::MUL_INC_HI: begin
            mul_a = $signed({8'b0, freq_ff});
            mul_b = $signed({2'b0, tuning_ff[39:20]});
         end
         ovwp_pkg::MUL_IDX: begin
            mul_a = $signed({2'b0, phase_ff[29:0]});
            mul_b = 22'(SINE_TABLE_DEPTH);
         end
         ovwp_pkg::MUL_GAIN: begin
            mul_a = 32'(wave_ff);
            mul_b = 22'(vol_ff);
         end
         ovwp_pkg::MUL_LEFT_HI: begin
            mul_a = 32'($signed(gain_ff[32:16]));
            mul_b = 22'(fac_left);
         end
         ovwp_pkg::MUL_LEFT_LO: begin
            mul_a = $signed({16'b0, gain_ff[15:0]});
            mul_b = 22'(fac_left);
         end
         ovwp_pkg::MUL_RIGHT_HI: begin
            mul_a = 32'($signed(gain_ff[32:16]));
            mul_b = 22'(fac_right);
         end
         ovwp_pkg::MUL_RIGHT_LO: begin
            mul_a = $signed({16'b0, gain_ff[15:0]});
            mul_b = 22'(fac_right);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // increment = bits 55..24 of freq * tuning, from two partial products
   assign inc_sum = {12'b0, part_ff[43:0]} + {prod_ff[35:0], 20'b0};
   assign inc_in  = inc_sum[55:24];

   assign idx_raw = prod_ff[30 +: IDX_W];
   assign idx_m   = phase_ff[30] ? (IDX_W'(SINE_TABLE_DEPTH - 1) - idx_raw) : idx_raw;

   assign tri_u = phase_ff[31:15];

   always_comb begin
      case (wave_sel_ff)
         ovwp_pkg::WAVE_SINE:
            wave_in = phase_ff[31] ? -$signed({1'b0, rom_ff}) : $signed({1'b0, rom_ff});
         ovwp_pkg::WAVE_SQUARE:
            wave_in = ((phase_ff != '0) && !phase_ff[31]) ? -17'sd32768 : 17'sd32768;
         ovwp_pkg::WAVE_SAW:
            wave_in = 17'($signed({~phase_ff[31], phase_ff[30:16]}));
         ovwp_pkg::WAVE_TRIANGLE: begin
            if (tri_u < 17'd32768) begin
               wave_in = $signed(tri_u);
            end else if (tri_u < 17'd98304) begin
               wave_in = $signed(17'd65536 - tri_u);
            end else begin
               wave_in = $signed(tri_u);
            end
         end
         default: wave_in = '0;
      endcase
   end

   assign mono_in  = ovwp_pkg::sat24((prod_ff + 54'sd128) >>> 8);
   assign pan_sum  = ((part_ff <<< 16) + prod_ff + 54'sd8388608) >>> 24;
   assign left_in  = ovwp_pkg::sat24(pan_sum);
   assign right_in = ovwp_pkg::sat24(pan_sum);

   always_ff @(posedge clock) begin
      if (load) begin
         freq_ff <= req_data.frequency;
         vol_ff  <= req_data.volume;
         pan_ff  <= req_data.pan;
      end
      if (cmd.mul_en)  prod_ff <= prod_in;
      if (cmd.part_en) part_ff <= prod_ff;
      if (cmd.inc_en)  inc_ff  <= inc_in;
      if (cmd.rom_en)  rom_ff  <= SINE_ROM[idx_m];
      if (cmd.wave_en) wave_ff <= wave_in;
      if (cmd.gain_en) gain_ff <= prod_ff[32:0];
      if (cmd.mono_en) begin
         left_ff  <= mono_in;
         right_ff <= '0;
      end
      if (cmd.left_en)  left_ff  <= left_in;
      if (cmd.right_en) right_ff <= right_in;
      if (cmd.finish && out_free) begin
         rsp_data_ff.left_sample  <= left_ff;
         rsp_data_ff.right_sample <= right_ff;
      end
   end

   // phase restarts when the volume leaves zero, advances once the item is out
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         prev_zero_ff <= 1'b1;
      end else if (load) begin
         if (prev_zero_ff && (req_data.volume != '0)) phase_ff <= '0;
         prev_zero_ff <= (req_data.volume == '0);
      end else if (cmd.finish && out_free) begin
         phase_ff <= phase_ff + inc_ff;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.stereo   = stereo_ff;
   assign sts.out_free = out_free;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

endmodule

/* rtl/oscillator_voice_with_pan.sv */
`timescale 1ns / 1ps
// Items are taken one at a time: req_stall is high while the controller steps the
// single shared 32x22 multiplier through its states; mono skips the pan states.
// Done items wait in ST_DONE for the output register; the next is taken once loaded.
// Reset (synchronous, active high): phase 0, volume flag set, CSRs to defaults.

module oscillator_voice_with_pan #(
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [ovwp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ovwp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ovwp_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ovwp_pkg::rsp_type                rsp_data
);

   ovwp_pkg::cmd_type cmd;
   ovwp_pkg::sts_type sts;
   logic              busy;
   logic              accept;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   ovwp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .sts    (sts),
      .busy   (busy),
      .cmd    (cmd)
   );

   ovwp_datapath #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .load         (accept),
      .req_data     (req_data),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("controller not busy after item accept");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> !$rose(rsp_valid))
      else $error("result appeared directly after accept");

   a_mono_right_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !sts.stereo) |-> (rsp_data.right_sample == '0))
      else $error("right sample not zero in mono");

   a_finish_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && !sts.out_free) |=> $stable(rsp_data))
      else $error("output overwritten while stalled");

endmodule

/* verif/oscillator_voice_with_pan_check.sv */
`timescale 1ns / 1ps

module oscillator_voice_with_pan_check #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [ovwp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ovwp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  ovwp_pkg::req_type                req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  ovwp_pkg::rsp_type                rsp_data,
   output int                               failures,
   output int                               pending
);
   import ovwp_pkg::*;

   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

   logic [15:0] sine_quarter [TABLE_DEPTH];
   logic [31:0] phase;
   logic        vol_was_zero;
   wave_type    wave;
   logic        stereo;
   logic [39:0] tuning;
   rsp_type     samples_due [$];
   int          fault_count = 0;

   // Q30 Taylor series to x^13, rounded to Q15
   function automatic logic [15:0] sine_entry(int i);
      longint unsigned x;
      longint unsigned term;
      longint          acc;
      longint          v;
      x = PI_HALF_Q30 * (2 * i + 1) / (2 * TABLE_DEPTH);
      term = x;
      acc = longint'(x);
      for (int k = 1; k <= 6; k++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / ((2 * k) * (2 * k + 1));
         if (k % 2) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      v = (acc * 32767 + 536870912) >>> 30;
      if (v > 32767) begin
         v = 32767;
      end
      return v[15:0];
   endfunction

   function automatic int wave_at(wave_type shape, logic [31:0] p);
      longint unsigned idx;
      int              s;
      int              u;
      case (shape)
         WAVE_SINE: begin
            idx = ({34'd0, p[29:0]} * TABLE_DEPTH) >> 30;
            if (idx >= TABLE_DEPTH) begin
               idx = 64'(TABLE_DEPTH - 1);
            end
            if (p[30]) begin
               idx = 64'(TABLE_DEPTH - 1) - idx;
            end
            s = int'(sine_quarter[idx]);
            return p[31] ? -s : s;
         end
         WAVE_SQUARE: begin
            return (p != 32'd0 && !p[31]) ? -32768 : 32768;
         end
         WAVE_SAW: begin
            return int'(p[31:16]) - 32768;
         end
         default: begin
            u = int'(p[31:15]);
            if (u < 32768) begin
               return u;
            end else if (u < 98304) begin
               return 65536 - u;
            end
            return u - 131072;
         end
      endcase
   endfunction

   function automatic logic signed [23:0] round_sat(longint x, int n);
      longint r;
      r = (x + (longint'(1) << (n - 1))) >>> n;
      if (r > 8388607) begin
         r = 8388607;
      end else if (r < -8388608) begin
         r = -8388608;
      end
      return r[23:0];
   endfunction

   // advances the voice state by one item
   function automatic rsp_type synth_sample(req_type note);
      logic [63:0] wide;
      longint      gain_prod;
      rsp_type     s;
      wide = {40'd0, note.frequency} * {24'd0, tuning};
      if (vol_was_zero && note.volume != 16'sd0) begin
         phase = '0;
      end
      vol_was_zero = (note.volume == 16'sd0);
      gain_prod = longint'(wave_at(wave, phase)) * longint'(note.volume);
      if (stereo) begin
         s.left_sample  = round_sat(gain_prod * (32768 - longint'(note.pan)), 24);
         s.right_sample = round_sat(gain_prod * (32768 + longint'(note.pan)), 24);
      end else begin
         s.left_sample  = round_sat(gain_prod, 8);
         s.right_sample = '0;
      end
      phase = phase + wide[55:24];
      return s;
   endfunction

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         sine_quarter[i] = sine_entry(i);
      end
   end

   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         samples_due.delete();
         phase = '0;
         vol_was_zero = 1'b1;
         wave = WAVE_SINE;
         stereo = 1'b1;
         tuning = TUNING_RESET;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_WAVEFORM: wave = wave_type'(csr_wdata[1:0]);
               CSR_STEREO:   stereo = csr_wdata[0];
               CSR_TUNING:   tuning = csr_wdata[39:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            samples_due.push_back(synth_sample(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (samples_due.size() == 0) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("unexpected sample L=%0d R=%0d at %0t",
                           rsp_data.left_sample, rsp_data.right_sample, $realtime);
               end
            end else begin
               due = samples_due.pop_front();
               if (rsp_data.left_sample != due.left_sample ||
                   rsp_data.right_sample != due.right_sample) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("sample mismatch at %0t: expected L=%0d R=%0d, got L=%0d R=%0d",
                              $realtime, due.left_sample, due.right_sample,
                              rsp_data.left_sample, rsp_data.right_sample);
                  end
               end
            end
         end
      end
      failures <= fault_count;
      pending  <= samples_due.size();
   end

endmodule

/* verif/oscillator_voice_with_pan_test.sv */
`timescale 1ns / 1ps

module oscillator_voice_with_pan_test;
   import ovwp_pkg::*;

   localparam int TABLE_DEPTH   = 256;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 300;
   localparam int BLOCK_ITEMS   = 100;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [39:0] TUNING_MAX = '1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   int                     failures;
   int                     pending;
   int                     sender_idle_pct = 19;
   int                     receiver_idle_pct = 58;
   int                     hold_requests = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   oscillator_voice_with_pan #(.SINE_TABLE_DEPTH(TABLE_DEPTH)) DUT (.*);

   oscillator_voice_with_pan_check #(.TABLE_DEPTH(TABLE_DEPTH)) voice_check (.*);

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_voice(input wave_type shape, input logic stereo,
                            input logic [39:0] tuning);
      write_reg(CSR_WAVEFORM, CSR_DATA_W'(shape));
      write_reg(CSR_STEREO, CSR_DATA_W'(stereo));
      write_reg(CSR_TUNING, tuning);
   endtask

   task automatic send_note(input req_type note);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= note;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_voice();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic req_type directed_note(int k);
      req_type n;
      case (k)
         0:       n = '{24'd0, 16'sd0, 16'sd0};
         1:       n = '{24'hFFFFFF, 16'sh7FFF, 16'sh8000};
         2:       n = '{24'hFFFFFF, 16'sh8000, 16'sh7FFF};
         3:       n = '{24'd1, 16'sd0, 16'sd0};
         4:       n = '{24'd12345, 16'sd4096, 16'sd0};
         default: n = '{24'h800000, 16'shFFFF, 16'shFFFF};
      endcase
      return n;
   endfunction

   function automatic req_type random_note();
      req_type n;
      case ($urandom_range(3))
         0:       n.frequency = 24'($urandom_range(4095));
         1:       n.frequency = $urandom_range(1) ? 24'hFFFFFF : 24'd0;
         default: n.frequency = 24'($urandom);
      endcase
      case ($urandom_range(19))
         0, 1:    n.volume = 16'sd0;
         2:       n.volume = 16'sh7FFF;
         3:       n.volume = 16'sh8000;
         default: n.volume = 16'($urandom);
      endcase
      case ($urandom_range(9))
         0:       n.pan = 16'sh7FFF;
         1:       n.pan = 16'sh8000;
         2:       n.pan = 16'sd0;
         default: n.pan = 16'($urandom);
      endcase
      return n;
   endfunction

   function automatic logic [39:0] pick_tuning(int b);
      if (b == 4) begin
         return 40'd0;
      end else if (b == 7) begin
         return TUNING_MAX;
      end else if (b % 2) begin
         return TUNING_RESET;
      end
      return {8'($urandom_range(255)), 32'($urandom)};
   endfunction

   initial begin : receiver
      int hold_left;
      int seen_holds;
      hold_left = 0;
      seen_holds = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != seen_holds) begin
            seen_holds = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // write to a spare index must leave the defaults alone
      write_reg(CSR_UNUSED, '1);
      for (int k = 0; k < 6; k++) begin
         send_note(directed_note(k));
      end
      drain_voice();
      set_voice(WAVE_SQUARE, 1'b0, TUNING_MAX);
      for (int k = 0; k < 6; k++) begin
         send_note(directed_note(k));
      end
      drain_voice();
      set_voice(WAVE_SAW, 1'b1, 40'h0001000000);
      for (int k = 0; k < 6; k++) begin
         send_note(directed_note(k));
      end
      drain_voice();
      set_voice(WAVE_TRIANGLE, 1'b0, TUNING_RESET);
      for (int k = 0; k < 6; k++) begin
         send_note(directed_note(k));
      end

      for (int b = 0; b < 9; b++) begin
         drain_voice();
         if (b == 3) begin
            sender_idle_pct <= 58;
            receiver_idle_pct <= 19;
         end else if (b == 6) begin
            sender_idle_pct <= 0;
            receiver_idle_pct <= 0;
         end
         set_voice(wave_type'(b % 4), 1'((b % 2) ^ ((b / 4) % 2)), pick_tuning(b));
         // long output back-pressure while items keep coming
         if (b == 1) begin
            hold_requests <= hold_requests + 1;
         end
         for (int i = 0; i < BLOCK_ITEMS; i++) begin
            send_note(random_note());
         end
      end

      drain_voice();
      if (failures == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/ovwp_pkg.sv
rtl/ovwp_ctrl.sv
rtl/ovwp_datapath.sv
rtl/oscillator_voice_with_pan.sv
verif/oscillator_voice_with_pan_check.sv
verif/oscillator_voice_with_pan_test.sv
